@@ hdl/mpt_pkg.sv @@
package mpt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int POS_BITS       = 16;
  localparam int DELTA_BITS     = 9;

  // header bit positions
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_X    = 3'b010,
    PH_Y    = 3'b100
  } phase_t;

  // one command handed from the front to the back
  typedef struct packed {
    op_t                           kind;
    logic [POS_BITS-1:0]           set_x;
    logic [POS_BITS-1:0]           set_y;
    logic signed [DELTA_BITS-1:0]  dx;
    logic signed [DELTA_BITS-1:0]  dy;
    logic                          left;
    logic                          right;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

@@ hdl/mpt_front.sv @@
module mpt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       set_x,
  input  logic [15:0]       set_y,
  input  mpt_pkg::q_status_t q_status,
  output logic              q_push,
  output mpt_pkg::cmd_t     q_cmd
);

  mpt_pkg::phase_t phase, phase_next;
  logic [7:0]      header_byte;
  logic [7:0]      x_byte;
  logic            accept;
  logic            is_set;
  logic            x_neg, y_neg;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign is_set   = (mpt_pkg::op_t'(operation) == mpt_pkg::OP_SET);

  assign q_push = accept && (is_set || phase == mpt_pkg::PH_Y);

  // a nonzero byte with its sign bit set means byte - 256
  assign x_neg = (x_byte != 8'd0) && header_byte[mpt_pkg::HDR_XSIGN];
  assign y_neg = (data_byte != 8'd0) && header_byte[mpt_pkg::HDR_YSIGN];

  always_comb begin
    q_cmd       = '0;
    q_cmd.kind  = is_set ? mpt_pkg::OP_SET : mpt_pkg::OP_BYTE;
    q_cmd.set_x = set_x;
    q_cmd.set_y = set_y;
    q_cmd.dx    = {x_neg, x_byte};
    q_cmd.dy    = {y_neg, data_byte};
    q_cmd.left  = header_byte[mpt_pkg::HDR_LEFT];
    q_cmd.right = header_byte[mpt_pkg::HDR_RIGHT];
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      mpt_pkg::PH_HEAD: phase_next = data_byte[mpt_pkg::HDR_SYNC] ? mpt_pkg::PH_X
                                                                  : mpt_pkg::PH_HEAD;
      mpt_pkg::PH_X:    phase_next = mpt_pkg::PH_Y;
      mpt_pkg::PH_Y:    phase_next = mpt_pkg::PH_HEAD;
      default:          phase_next = mpt_pkg::PH_HEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mpt_pkg::PH_HEAD;
      header_byte <= 8'd0;
      x_byte      <= 8'd0;
    end else if (accept && !is_set) begin
      phase <= phase_next;
      if (phase == mpt_pkg::PH_X) begin
        x_byte <= data_byte;
      end else if (phase == mpt_pkg::PH_HEAD) begin
        header_byte <= data_byte;
      end
    end
  end

endmodule

@@ hdl/mpt_queue.sv @@
module mpt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mpt_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output mpt_pkg::cmd_t      head_cmd,
  output mpt_pkg::q_status_t status
);

  // two entries: enough for one item a cycle while out_ready is high, with a registered back end
  mpt_pkg::cmd_t entry [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);
  assign head_cmd     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end else begin
        count <= count;
      end
    end
  end

endmodule

@@ hdl/mpt_back.sv @@
module mpt_back #(
  parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mpt_pkg::q_status_t     q_status,
  input  mpt_pkg::cmd_t          q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            pos_x,
  output logic [15:0]            pos_y,
  output logic signed [8:0]      delta_x,
  output logic signed [8:0]      delta_y,
  output logic                   left_pressed,
  output logic                   right_pressed
);

  // signed work width: holds a position, a 16-bit load and a 9-bit delta
  localparam int SW = ((COORD_BITS > mpt_pkg::POS_BITS) ? COORD_BITS
                                                        : mpt_pkg::POS_BITS) + 2;
  localparam logic signed [SW-1:0] MAXW = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  logic [COORD_BITS-1:0] cursor_x, cursor_y;
  logic [COORD_BITS-1:0] new_x, new_y;
  logic signed [SW-1:0]  ax, ay;
  logic [SW-1:0]         wide_x, wide_y;
  logic                  is_set;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > MAXW) begin
      r = '1;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign is_set = (q_cmd.kind == mpt_pkg::OP_SET);
  // a load never waits on the output register
  assign q_pop  = q_status.valid && (is_set || !out_valid || out_ready);

  always_comb begin
    if (is_set) begin
      ax = $signed(SW'(q_cmd.set_x));
      ay = $signed(SW'(q_cmd.set_y));
    end else begin
      ax = $signed(SW'(cursor_x)) + {{(SW-mpt_pkg::DELTA_BITS){q_cmd.dx[8]}}, q_cmd.dx};
      ay = $signed(SW'(cursor_y)) - {{(SW-mpt_pkg::DELTA_BITS){q_cmd.dy[8]}}, q_cmd.dy};
    end
    new_x  = clamp(ax);
    new_y  = clamp(ay);
    wide_x = SW'(new_x);
    wide_y = SW'(new_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x  <= '0;
      cursor_y  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && !is_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cursor_x <= new_x;
        cursor_y <= new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !is_set) begin
      pos_x         <= wide_x[15:0];
      pos_y         <= wide_y[15:0];
      delta_x       <= q_cmd.dx;
      delta_y       <= q_cmd.dy;
      left_pressed  <= q_cmd.left;
      right_pressed <= q_cmd.right;
    end
  end

endmodule

@@ hdl/mouse_packet_tracker_core.sv @@
// Mouse packet tracker: takes one item per cycle, either a received mouse
// byte or a cursor load. Bytes form three-byte packets (a header needs bit 3
// set); each completed packet moves the cursor, clamped to 0 and to
// 2^COORD_BITS-1, and yields one result with the positions, the signed
// deltas and the left/right buttons. Loads and non-final bytes yield nothing.
// The front end classifies items at one per cycle into a two-entry queue;
// the back end updates the cursor and fills the output register, so a
// completing byte passes through the queue and then the output register
// before out_valid rises, and the full rate of one item per cycle holds
// while out_ready is high.
module mouse_packet_tracker_core #(
  parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       set_x,
  input  logic [15:0]       set_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       pos_x,
  output logic [15:0]       pos_y,
  output logic signed [8:0] delta_x,
  output logic signed [8:0] delta_y,
  output logic              left_pressed,
  output logic              right_pressed
);

  mpt_pkg::q_status_t q_status;
  mpt_pkg::cmd_t      push_cmd, head_cmd;
  logic               q_push, q_pop;

  mpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .data_byte (data_byte),
    .set_x     (set_x),
    .set_y     (set_y),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mpt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  mpt_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .left_pressed  (left_pressed),
    .right_pressed (right_pressed)
  );

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !in_ready)
    else $error("input taken while queue full");

  a_load_enqueued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation) |-> q_push)
    else $error("cursor load not queued");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.valid)
    else $error("pop from empty queue");

  a_packet_gives_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && head_cmd.kind == mpt_pkg::OP_BYTE) |=> out_valid)
    else $error("packet popped without result");

endmodule
